### rtl/rmq_pkg.sv
// Shared types for the rotation matrix to quaternion pipeline.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package rmq_pkg;

    // Which component takes the square root half
    typedef enum logic [1:0] {
        SEL_TRACE = 2'd0,
        SEL_X     = 2'd1,
        SEL_Y     = 2'd2,
        SEL_Z     = 2'd3
    } sel_t;

    // Side data that rides along the root and reciprocal cells
    typedef struct packed {
        sel_t               sel;
        logic               degen;
        logic signed [16:0] op_a;
        logic signed [16:0] op_b;
        logic signed [16:0] op_c;
    } payload_t;

    localparam int ELEM_W = 16;
    localparam int OP_W   = 17;
    localparam int LO_W   = 24;

endpackage

`default_nettype wire

### rtl/rotation_matrix_to_quaternion.sv
// Top level: rotation matrix to unit quaternion, Shepperd's method.
// Depends on rmq_pkg, rmq_front, rmq_sqrt_cell, rmq_div_cell and rmq_mul.
//
// Usage:
//   Slave channel s_* takes one matrix per word, m00 in the lowest 16 bits
//   through m22 in the highest, signed, FRAC_BITS fraction bits.
//   Master channel m_* gives one quaternion per word: qw, qx, qy, qz in
//   m_tdata, and the degenerate flag in m_tuser (all components zero then).
//   Throughput: one word per cycle while the receiver does not stall.
//   Each word passes the input stage, the chain of square root cells (one
//   root bit per cell), the chain of restoring divider cells (one reciprocal
//   bit per cell), then two multiply stages.
//   All stages advance together; when the receiver stalls with a word
//   waiting, the whole chain holds and s_tready drops. Reset clears all
//   valid flags; the block is ready as soon as reset ends.
`timescale 1ns / 1ps
`default_nettype none

module rotation_matrix_to_quaternion #(
    parameter int FRAC_BITS = 14
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    // m00, m01, m02, m10, m11, m12, m20, m21, m22
    input  wire logic [143:0]  s_tdata,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    // qw, qx, qy, qz
    output logic [63:0]        m_tdata,
    // degenerate
    output logic [0:0]         m_tuser
);

    localparam int RW     = (((FRAC_BITS + 2) > 18) ? (FRAC_BITS + 2) : 18) + 1;
    localparam int ROOT_W = (RW + FRAC_BITS) / 2;
    localparam int NW     = 2 * ROOT_W;
    localparam int Q_W    = 2 * FRAC_BITS;

    logic ce;

    logic                 sq_v    [ROOT_W+1];
    logic [NW-1:0]        sq_n    [ROOT_W+1];
    logic [ROOT_W-1:0]    sq_root [ROOT_W+1];
    logic [ROOT_W+2:0]    sq_rem  [ROOT_W+1];
    rmq_pkg::payload_t    sq_pay  [ROOT_W+1];

    logic                 dv_v    [Q_W+1];
    logic [ROOT_W-1:0]    dv_root [Q_W+1];
    logic [ROOT_W:0]      dv_rem  [Q_W+1];
    logic [Q_W-1:0]       dv_q    [Q_W+1];
    rmq_pkg::payload_t    dv_pay  [Q_W+1];

    // Advance everything unless a finished word is held
    assign ce       = !m_tvalid || m_tready;
    assign s_tready = ce;

    rmq_front #(
        .FRAC_BITS (FRAC_BITS),
        .RW        (RW),
        .NW        (NW)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .valid_in  (s_tvalid),
        .mat_in    (s_tdata),
        .valid_out (sq_v[0]),
        .n_out     (sq_n[0]),
        .pay_out   (sq_pay[0])
    );

    assign sq_root[0] = '0;
    assign sq_rem[0]  = '0;

    // Square root chain
    for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt
        rmq_sqrt_cell #(
            .ROOT_W (ROOT_W)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ce        (ce),
            .valid_in  (sq_v[g]),
            .n_in      (sq_n[g]),
            .root_in   (sq_root[g]),
            .rem_in    (sq_rem[g]),
            .pay_in    (sq_pay[g]),
            .valid_out (sq_v[g+1]),
            .n_out     (sq_n[g+1]),
            .root_out  (sq_root[g+1]),
            .rem_out   (sq_rem[g+1]),
            .pay_out   (sq_pay[g+1])
        );
    end

    assign dv_v[0]    = sq_v[ROOT_W];
    assign dv_root[0] = sq_root[ROOT_W];
    assign dv_rem[0]  = '0;
    assign dv_q[0]    = '0;
    assign dv_pay[0]  = sq_pay[ROOT_W];

    // Reciprocal chain: 2^(2*FRAC_BITS-1) / root, top dividend bit first
    for (genvar g = 0; g < Q_W; g++) begin : g_div
        rmq_div_cell #(
            .ROOT_W (ROOT_W),
            .Q_W    (Q_W),
            .DBIT   ((g == 0) ? 1'b1 : 1'b0)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ce        (ce),
            .valid_in  (dv_v[g]),
            .root_in   (dv_root[g]),
            .rem_in    (dv_rem[g]),
            .q_in      (dv_q[g]),
            .pay_in    (dv_pay[g]),
            .valid_out (dv_v[g+1]),
            .root_out  (dv_root[g+1]),
            .rem_out   (dv_rem[g+1]),
            .q_out     (dv_q[g+1]),
            .pay_out   (dv_pay[g+1])
        );
    end

    rmq_mul #(
        .FRAC_BITS (FRAC_BITS),
        .ROOT_W    (ROOT_W),
        .Q_W       (Q_W)
    ) u_mul (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .valid_in  (dv_v[Q_W]),
        .root_in   (dv_root[Q_W]),
        .q_in      (dv_q[Q_W]),
        .pay_in    (dv_pay[Q_W]),
        .valid_out (m_tvalid),
        .q_data    (m_tdata),
        .degen_out (m_tuser[0])
    );

endmodule

`default_nettype wire

### rtl/rmq_front.sv
// Input stage: trace test, dominant diagonal choice, radicand and operands.
// Depends on rmq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rmq_front #(
    parameter int FRAC_BITS = 14,
    parameter int RW        = 19,
    parameter int NW        = 32
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                ce,
    input  wire logic                valid_in,
    input  wire logic [143:0]        mat_in,
    output logic                     valid_out,
    output logic [NW-1:0]            n_out,
    output rmq_pkg::payload_t        pay_out
);

    logic                     valid_reg;
    logic [NW-1:0]            n_reg, n_next;
    rmq_pkg::payload_t        pay_reg, pay_next;

    logic signed [15:0]       m00, m01, m02, m10, m11, m12, m20, m21, m22;
    logic signed [RW-1:0]     one, trace, rad, dii, djj, dkk;
    logic                     trace_pos;

    assign m00 = $signed(mat_in[15:0]);
    assign m01 = $signed(mat_in[31:16]);
    assign m02 = $signed(mat_in[47:32]);
    assign m10 = $signed(mat_in[63:48]);
    assign m11 = $signed(mat_in[79:64]);
    assign m12 = $signed(mat_in[95:80]);
    assign m20 = $signed(mat_in[111:96]);
    assign m21 = $signed(mat_in[127:112]);
    assign m22 = $signed(mat_in[143:128]);

    // Pick branch, build radicand and the three off-diagonal operands
    always_comb begin
        one       = RW'(1) <<< FRAC_BITS;
        trace     = RW'(m00) + RW'(m11) + RW'(m22);
        trace_pos = (trace > 0);
        dii       = RW'(m00);
        djj       = RW'(m11);
        dkk       = RW'(m22);
        pay_next.sel  = rmq_pkg::SEL_TRACE;
        pay_next.op_a = 17'(m21) - 17'(m12);
        pay_next.op_b = 17'(m02) - 17'(m20);
        pay_next.op_c = 17'(m10) - 17'(m01);
        if (!trace_pos) begin
            if (m22 > ((m11 > m00) ? m11 : m00)) begin
                pay_next.sel  = rmq_pkg::SEL_Z;
                dii = RW'(m22); djj = RW'(m00); dkk = RW'(m11);
                pay_next.op_a = 17'(m10) - 17'(m01);
                pay_next.op_b = 17'(m02) + 17'(m20);
                pay_next.op_c = 17'(m12) + 17'(m21);
            end else if (m11 > m00) begin
                pay_next.sel  = rmq_pkg::SEL_Y;
                dii = RW'(m11); djj = RW'(m22); dkk = RW'(m00);
                pay_next.op_a = 17'(m02) - 17'(m20);
                pay_next.op_b = 17'(m21) + 17'(m12);
                pay_next.op_c = 17'(m01) + 17'(m10);
            end else begin
                pay_next.sel  = rmq_pkg::SEL_X;
                pay_next.op_a = 17'(m21) - 17'(m12);
                pay_next.op_b = 17'(m10) + 17'(m01);
                pay_next.op_c = 17'(m20) + 17'(m02);
            end
        end
        rad = trace_pos ? (trace + one) : (dii - djj - dkk + one);
        pay_next.degen = !trace_pos && (rad <= 0);
        // Feed a harmless radicand when degenerate; outputs are zeroed later
        if (pay_next.degen) begin
            n_next = NW'(1) << FRAC_BITS;
        end else begin
            n_next = NW'(rad[RW-2:0]) << FRAC_BITS;
        end
    end

    // Register the stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ce) begin
            valid_reg <= valid_in;
        end
        if (ce) begin
            n_reg   <= n_next;
            pay_reg <= pay_next;
        end
    end

    assign valid_out = valid_reg;
    assign n_out     = n_reg;
    assign pay_out   = pay_reg;

endmodule

`default_nettype wire

### rtl/rmq_sqrt_cell.sv
// One cell of the square root chain: resolves one root bit per cycle while ce is high.
// Depends on rmq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rmq_sqrt_cell #(
    parameter int ROOT_W = 16
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  ce,
    input  wire logic                  valid_in,
    input  wire logic [2*ROOT_W-1:0]   n_in,
    input  wire logic [ROOT_W-1:0]     root_in,
    input  wire logic [ROOT_W+2:0]     rem_in,
    input  wire rmq_pkg::payload_t     pay_in,
    output logic                       valid_out,
    output logic [2*ROOT_W-1:0]        n_out,
    output logic [ROOT_W-1:0]          root_out,
    output logic [ROOT_W+2:0]          rem_out,
    output rmq_pkg::payload_t          pay_out
);

    localparam int NW   = 2 * ROOT_W;
    localparam int REMW = ROOT_W + 3;

    logic                valid_reg;
    logic [NW-1:0]       n_reg, n_next;
    logic [ROOT_W-1:0]   root_reg, root_next;
    logic [REMW-1:0]     rem_reg, rem_next, rem_sh, trial;
    rmq_pkg::payload_t   pay_reg;

    // Bring down two radicand bits and try the next root bit
    always_comb begin
        rem_sh = {rem_in[REMW-3:0], n_in[NW-1:NW-2]};
        trial  = {1'b0, root_in, 2'b01};
        n_next = n_in << 2;
        if (rem_sh >= trial) begin
            rem_next  = rem_sh - trial;
            root_next = {root_in[ROOT_W-2:0], 1'b1};
        end else begin
            rem_next  = rem_sh;
            root_next = {root_in[ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ce) begin
            valid_reg <= valid_in;
        end
        if (ce) begin
            n_reg    <= n_next;
            root_reg <= root_next;
            rem_reg  <= rem_next;
            pay_reg  <= pay_in;
        end
    end

    assign valid_out = valid_reg;
    assign n_out     = n_reg;
    assign root_out  = root_reg;
    assign rem_out   = rem_reg;
    assign pay_out   = pay_reg;

endmodule

`default_nettype wire

### rtl/rmq_div_cell.sv
// One cell of the reciprocal chain: one restoring division step per cycle while ce is high.
// Depends on rmq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rmq_div_cell #(
    parameter int ROOT_W = 16,
    parameter int Q_W    = 28,
    parameter bit DBIT   = 1'b0
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  ce,
    input  wire logic                  valid_in,
    input  wire logic [ROOT_W-1:0]     root_in,
    input  wire logic [ROOT_W:0]       rem_in,
    input  wire logic [Q_W-1:0]        q_in,
    input  wire rmq_pkg::payload_t     pay_in,
    output logic                       valid_out,
    output logic [ROOT_W-1:0]          root_out,
    output logic [ROOT_W:0]            rem_out,
    output logic [Q_W-1:0]             q_out,
    output rmq_pkg::payload_t          pay_out
);

    logic                valid_reg;
    logic [ROOT_W-1:0]   root_reg;
    logic [ROOT_W:0]     rem_reg, rem_next, rem_sh;
    logic [Q_W-1:0]      q_reg, q_next;
    rmq_pkg::payload_t   pay_reg;

    // Shift in the dividend bit, subtract the root if it fits
    always_comb begin
        rem_sh = {rem_in[ROOT_W-1:0], DBIT};
        if (rem_sh >= {1'b0, root_in}) begin
            rem_next = rem_sh - {1'b0, root_in};
            q_next   = {q_in[Q_W-2:0], 1'b1};
        end else begin
            rem_next = rem_sh;
            q_next   = {q_in[Q_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ce) begin
            valid_reg <= valid_in;
        end
        if (ce) begin
            root_reg <= root_in;
            rem_reg  <= rem_next;
            q_reg    <= q_next;
            pay_reg  <= pay_in;
        end
    end

    assign valid_out = valid_reg;
    assign root_out  = root_reg;
    assign rem_out   = rem_reg;
    assign q_out     = q_reg;
    assign pay_out   = pay_reg;

endmodule

`default_nettype wire

### rtl/rmq_mul.sv
// Scaling stages: operands times reciprocal, floor, saturate, place components.
// Depends on rmq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rmq_mul #(
    parameter int FRAC_BITS = 14,
    parameter int ROOT_W    = 16,
    parameter int Q_W       = 28
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  ce,
    input  wire logic                  valid_in,
    input  wire logic [ROOT_W-1:0]     root_in,
    input  wire logic [Q_W-1:0]        q_in,
    input  wire rmq_pkg::payload_t     pay_in,
    output logic                       valid_out,
    output logic [63:0]                q_data,
    output logic                       degen_out
);

    localparam int RC_W  = FRAC_BITS + 17;
    localparam int HI_W  = RC_W - rmq_pkg::LO_W;
    localparam int MX_W  = (Q_W > RC_W) ? Q_W : RC_W;
    localparam int PLO_W = rmq_pkg::OP_W + rmq_pkg::LO_W + 1;
    localparam int PHI_W = rmq_pkg::OP_W + HI_W + 1;
    localparam int P_W   = rmq_pkg::OP_W + RC_W + 1;

    logic                        va_reg, vb_reg;
    logic [MX_W-1:0]             q_ext, clamp;
    logic [RC_W-1:0]             rc;
    logic signed [rmq_pkg::LO_W:0] lo_s;
    logic signed [HI_W:0]        hi_s;
    logic signed [rmq_pkg::OP_W-1:0] ops [3];
    logic signed [PLO_W-1:0]     plo_reg [3], plo_next [3];
    logic signed [PHI_W-1:0]     phi_reg [3], phi_next [3];
    logic [15:0]                 half_reg, half_next;
    rmq_pkg::payload_t           pay_reg;
    logic signed [P_W-1:0]       sum [3], scl [3];
    logic [15:0]                 sat [3];
    logic [63:0]                 data_reg, data_next;
    logic                        degen_reg;

    // Clamp the reciprocal where any nonzero operand saturates anyway
    always_comb begin
        q_ext = MX_W'(q_in);
        clamp = MX_W'(1) << (FRAC_BITS + 16);
        rc    = (q_ext > clamp) ? clamp[RC_W-1:0] : q_ext[RC_W-1:0];
        lo_s  = $signed({1'b0, rc[rmq_pkg::LO_W-1:0]});
        hi_s  = $signed({1'b0, rc[RC_W-1:rmq_pkg::LO_W]});
        ops[0] = pay_in.op_a;
        ops[1] = pay_in.op_b;
        ops[2] = pay_in.op_c;
        for (int i = 0; i < 3; i++) begin
            plo_next[i] = PLO_W'(ops[i]) * PLO_W'(lo_s);
            phi_next[i] = PHI_W'(ops[i]) * PHI_W'(hi_s);
        end
        if ((root_in >> 1) > ROOT_W'(32767)) begin
            half_next = 16'd32767;
        end else begin
            half_next = 16'(root_in >> 1);
        end
    end

    // Hold partial products
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
        end else if (ce) begin
            va_reg <= valid_in;
        end
        if (ce) begin
            for (int i = 0; i < 3; i++) begin
                plo_reg[i] <= plo_next[i];
                phi_reg[i] <= phi_next[i];
            end
            half_reg <= half_next;
            pay_reg  <= pay_in;
        end
    end

    // Combine, floor, saturate and route the components
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sum[i] = (P_W'(phi_reg[i]) <<< rmq_pkg::LO_W) + P_W'(plo_reg[i]);
            scl[i] = sum[i] >>> FRAC_BITS;
            if (scl[i] > P_W'(32767)) begin
                sat[i] = 16'h7fff;
            end else if (scl[i] < -P_W'(32768)) begin
                sat[i] = 16'h8000;
            end else begin
                sat[i] = scl[i][15:0];
            end
        end
        unique case (pay_reg.sel)
            rmq_pkg::SEL_TRACE: data_next = {sat[2], sat[1], sat[0], half_reg};
            rmq_pkg::SEL_X:     data_next = {sat[2], sat[1], half_reg, sat[0]};
            rmq_pkg::SEL_Y:     data_next = {sat[1], half_reg, sat[2], sat[0]};
            rmq_pkg::SEL_Z:     data_next = {half_reg, sat[2], sat[1], sat[0]};
            default:            data_next = '0;
        endcase
        if (pay_reg.degen) begin
            data_next = '0;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vb_reg <= 1'b0;
        end else if (ce) begin
            vb_reg <= va_reg;
        end
        if (ce) begin
            data_reg  <= data_next;
            degen_reg <= pay_reg.degen;
        end
    end

    assign valid_out = vb_reg;
    assign q_data    = data_reg;
    assign degen_out = degen_reg;

endmodule

`default_nettype wire

### verif/tb_top.sv
// Testbench for rotation_matrix_to_quaternion: random and directed matrices,
// checked word by word against a fixed point Shepperd predictor in a scoreboard.
// Depends on rtl/rotation_matrix_to_quaternion.sv and its sub-modules.
`timescale 1ns / 1ps

class quat_scoreboard;
    localparam int FB = 14;
    logic [64:0] pending[$];
    int errors;

    function new();
        errors = 0;
    endfunction

    static function logic signed [15:0] clamp16(longint v);
        if (v > 32767) return 16'sd32767;
        if (v < -32768) return -16'sd32768;
        return v[15:0];
    endfunction

    static function longint floor_shift(longint p);
        return p >>> FB;
    endfunction

    static function longint int_sqrt(longint n);
        longint r;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            if ((r + (longint'(1) << b)) * (r + (longint'(1) << b)) <= n)
                r = r + (longint'(1) << b);
        end
        return r;
    endfunction

    // Compute {degenerate, qz, qy, qx, qw} for one matrix word
    static function logic [64:0] quat_of(logic [143:0] word);
        longint m[3][3];
        longint q[4];
        longint one, tr, rad, root, half, recip;
        int i, j, k;
        one = longint'(1) << FB;
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                m[r][c] = longint'($signed(word[(r*3+c)*16 +: 16]));
        tr = m[0][0] + m[1][1] + m[2][2];
        if (tr > 0) begin
            rad = tr + one;
            root = int_sqrt(rad << FB);
            half = root >> 1;
            recip = (longint'(1) << (2*FB-1)) / root;
            q[0] = half;
            q[1] = floor_shift((m[2][1] - m[1][2]) * recip);
            q[2] = floor_shift((m[0][2] - m[2][0]) * recip);
            q[3] = floor_shift((m[1][0] - m[0][1]) * recip);
        end else begin
            i = 0;
            if (m[1][1] > m[0][0]) i = 1;
            if (m[2][2] > m[i][i]) i = 2;
            j = (i + 1) % 3;
            k = (j + 1) % 3;
            rad = m[i][i] - m[j][j] - m[k][k] + one;
            if (rad <= 0) return {1'b1, 64'd0};
            root = int_sqrt(rad << FB);
            half = root >> 1;
            recip = (longint'(1) << (2*FB-1)) / root;
            q[1+i] = half;
            q[0] = floor_shift((m[k][j] - m[j][k]) * recip);
            q[1+j] = floor_shift((m[j][i] + m[i][j]) * recip);
            q[1+k] = floor_shift((m[k][i] + m[i][k]) * recip);
        end
        return {1'b0, clamp16(q[3]), clamp16(q[2]), clamp16(q[1]), clamp16(q[0])};
    endfunction

    function void note_matrix(logic [143:0] word);
        pending.push_back(quat_of(word));
    endfunction

    task report(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        errors++;
    endtask

    task check_quat(logic [63:0] data, logic deg);
        logic [64:0] e;
        string names[4] = '{"qw", "qx", "qy", "qz"};
        if (pending.size() == 0) begin
            $display("unexpected quaternion word at %0t", $time);
            errors++;
            return;
        end
        e = pending.pop_front();
        for (int n = 0; n < 4; n++)
            if (data[n*16 +: 16] !== e[n*16 +: 16])
                report(names[n], $signed(data[n*16 +: 16]), $signed(e[n*16 +: 16]));
        if (deg !== e[64]) report("degenerate", deg, e[64]);
    endtask
endclass

module tb_top;
    localparam int LATENCY = 47;
    localparam int WATCHDOG = 5000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [143:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic [0:0] m_tuser;

    quat_scoreboard sb = new();
    bit stim_done = 1'b0;
    int idle_cycles = 0;

    always #5 aclk = ~aclk;

    rotation_matrix_to_quaternion uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
        if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
        return 0;
    endfunction

    // Note accepted words and check results at the rising edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_matrix(s_tdata);
            if (m_tvalid && m_tready) sb.check_quat(m_tdata, m_tuser[0]);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
            else idle_cycles++;
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if (idle_cycles >= WATCHDOG) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Receiver: random stalls, with calm stretches
    initial begin
        int g;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            g = ($urandom_range(0, 3) == 0) ? 0 : gap_len();
            if (g == 0) m_tready <= 1'b1;
            else begin
                m_tready <= 1'b0;
                repeat (g - 1) @(negedge aclk);
            end
        end
    end

    // Send one matrix, with a random gap first
    task automatic send_matrix(logic [143:0] word);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= word;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic logic [143:0] pack9(int e[9]);
        logic [143:0] w;
        for (int n = 0; n < 9; n++) w[n*16 +: 16] = e[n][15:0];
        return w;
    endfunction

    // Rotation-like matrix: permuted signed diagonal with small perturbation
    function automatic logic [143:0] rot_like();
        int e[9];
        int perm, s, mag;
        for (int n = 0; n < 9; n++) e[n] = $signed($urandom_range(0, 4000)) - 2000;
        perm = $urandom_range(0, 2);
        for (int r = 0; r < 3; r++) begin
            s = $urandom_range(0, 1) ? 1 : -1;
            mag = $urandom_range(9000, 16384);
            e[r*3 + (r + perm) % 3] = s * mag;
        end
        return pack9(e);
    endfunction

    function automatic logic [143:0] wild_matrix();
        int e[9];
        for (int n = 0; n < 9; n++)
            case ($urandom_range(0, 3))
                0: e[n] = $urandom_range(0, 32768) - 16384;
                1: e[n] = $signed(16'($urandom()));
                2: e[n] = $urandom_range(0, 1) ? 16384 : -16384;
                default: e[n] = $urandom_range(0, 200) - 100;
            endcase
        return pack9(e);
    endfunction

    initial begin
        int e[9];
        int wait_cnt;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: identity, axis flips, zero, extremes, ties, rotations
        e = '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384}; send_matrix(pack9(e));
        e = '{16384, 0, 0, 0, -16384, 0, 0, 0, -16384}; send_matrix(pack9(e));
        e = '{-16384, 0, 0, 0, 16384, 0, 0, 0, -16384}; send_matrix(pack9(e));
        e = '{-16384, 0, 0, 0, -16384, 0, 0, 0, 16384}; send_matrix(pack9(e));
        e = '{0, 0, 0, 0, 0, 0, 0, 0, 0}; send_matrix(pack9(e));
        e = '{-16384, 0, 0, 0, -16384, 0, 0, 0, -16384}; send_matrix(pack9(e));
        e = '{0, -16384, 0, 16384, 0, 0, 0, 0, 16384}; send_matrix(pack9(e));
        e = '{0, 16384, 0, 16384, 0, 0, 0, 0, -16384}; send_matrix(pack9(e));
        e = '{-8192, 100, 200, 300, -8192, 400, 500, 600, -8192}; send_matrix(pack9(e));
        e = '{-8192, 1, 2, 3, -8192, 4, 5, 6, -10000}; send_matrix(pack9(e));
        e = '{-10000, 1, 2, 3, -8192, 4, 5, 6, -8192}; send_matrix(pack9(e));
        e = '{32767, 32767, -32768, -32768, 32767, 32767, 32767, -32768, 32767};
        send_matrix(pack9(e));
        e = '{-32768, -32768, 32767, 32767, -32768, -32768, -32768, 32767, -32768};
        send_matrix(pack9(e));
        e = '{-1, -1, -1, -1, -1, -1, -1, -1, -1}; send_matrix(pack9(e));
        e = '{1, 32767, -32768, 32767, 0, -32768, 32767, -32768, -1};
        send_matrix(pack9(e));
        e = '{-16384, 32767, 32767, 32767, -16384, 32767, 32767, 32767, 32767};
        send_matrix(pack9(e));
        e = '{0, -32768, -32768, 32767, 0, -32768, 32767, 32767, 0}; send_matrix(pack9(e));

        // Drain fully once before the random part
        s_tvalid <= 1'b0;
        wait_cnt = 0;
        while (sb.pending.size() != 0 && wait_cnt < WATCHDOG) begin
            @(negedge aclk);
            wait_cnt++;
        end

        for (int n = 0; n < 1700; n++)
            send_matrix($urandom_range(0, 3) != 0 ? rot_like() : wild_matrix());
        s_tvalid <= 1'b0;
        stim_done = 1'b1;
    end

    // End of run: drain, settle, decide
    initial begin
        int cnt;
        wait (stim_done);
        cnt = 0;
        while (sb.pending.size() != 0 && cnt < 200000) begin
            @(posedge aclk);
            cnt++;
        end
        repeat (LATENCY + 20) @(posedge aclk);
        if (sb.errors == 0 && sb.pending.size() == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end
endmodule
